FILE: rtl/core/sidp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sidp_pkg;

  localparam int unsigned NameLenW = 10;
  localparam int unsigned IdW      = 16;

  typedef struct packed {
    logic                ok;
    logic [NameLenW-1:0] name_length;
    logic [IdW-1:0]      lib_code;
    logic [IdW-1:0]      mod_code;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/sidp_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module sidp_parse #(
  parameter int unsigned MAX_LEN         = 1024,
  parameter int unsigned MAX_CODE_DIGITS = 3
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       char_i,
  input  wire logic             last_i,
  output sidp_pkg::result_t     result_o
);

  localparam int unsigned PosW = $clog2(MAX_LEN + 2);
  localparam int unsigned CntW = $clog2(MAX_CODE_DIGITS + 1);
  localparam logic [7:0] HashChar = 8'h23;

  localparam logic [1:0] PhName = 2'd0;
  localparam logic [1:0] PhLib  = 2'd1;
  localparam logic [1:0] PhMod  = 2'd2;
  localparam logic [1:0] PhFail = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } digit_t;

  function automatic digit_t decode_digit(input logic [7:0] c);
    digit_t d;
    d.valid = 1'b1;
    d.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      d.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      d.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      d.value = 6'd62;
    end else if (c == 8'h2d) begin
      d.value = 6'd63;
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

  logic [1:0]                    phase_q, phase_d, phase_cur;
  logic [PosW-1:0]               pos_q, pos_d;
  logic [sidp_pkg::NameLenW-1:0] nlen_q, nlen_d;
  logic [sidp_pkg::IdW-1:0]      lib_q, lib_d, mod_q, mod_d;
  logic [CntW-1:0]               lib_cnt_q, lib_cnt_d, mod_cnt_q, mod_cnt_d;
  digit_t                        dig;

  always_comb begin
    dig       = decode_digit(char_i);
    pos_d     = pos_q;
    nlen_d    = nlen_q;
    lib_d     = lib_q;
    mod_d     = mod_q;
    lib_cnt_d = lib_cnt_q;
    mod_cnt_d = mod_cnt_q;
    if (pos_q <= PosW'(MAX_LEN)) begin
      pos_d = pos_q + 1'b1;
    end
    phase_cur = (pos_d > PosW'(MAX_LEN)) ? PhFail : phase_q;
    phase_d   = phase_cur;
    unique case (phase_cur)
      PhName: begin
        if (char_i == HashChar) begin
          phase_d = PhLib;
        end else begin
          nlen_d = nlen_q + 1'b1;
        end
      end
      PhLib: begin
        if (char_i == HashChar) begin
          phase_d = PhMod;
        end else if (!dig.valid || lib_cnt_q >= CntW'(MAX_CODE_DIGITS)) begin
          phase_d = PhFail;
        end else begin
          lib_d     = {lib_q[sidp_pkg::IdW-7:0], dig.value};
          lib_cnt_d = lib_cnt_q + 1'b1;
        end
      end
      PhMod: begin
        if (!dig.valid || mod_cnt_q >= CntW'(MAX_CODE_DIGITS)) begin
          phase_d = PhFail;
        end else begin
          mod_d     = {mod_q[sidp_pkg::IdW-7:0], dig.value};
          mod_cnt_d = mod_cnt_q + 1'b1;
        end
      end
      default: begin
      end
    endcase

    result_o = '0;
    if (phase_d == PhMod) begin
      result_o.ok          = 1'b1;
      result_o.name_length = nlen_d;
      result_o.lib_code    = lib_d;
      result_o.mod_code    = mod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhName;
      pos_q     <= '0;
      nlen_q    <= '0;
      lib_q     <= '0;
      mod_q     <= '0;
      lib_cnt_q <= '0;
      mod_cnt_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q   <= PhName;
        pos_q     <= '0;
        nlen_q    <= '0;
        lib_q     <= '0;
        mod_q     <= '0;
        lib_cnt_q <= '0;
        mod_cnt_q <= '0;
      end else begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        nlen_q    <= nlen_d;
        lib_q     <= lib_d;
        mod_q     <= mod_d;
        lib_cnt_q <= lib_cnt_d;
        mod_cnt_q <= mod_cnt_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/symbol_id_suffix_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A character is taken into the input register and parsed from there into the parse state;
//   the result of a final character goes into the result register that drives the outputs.
// Throughput: one character per cycle, set by the single parse stage after the input register;
//   a final character waits only while the previous result is still held and not taken.
// Reset: asynchronous, active low; empties both registers and returns to the name part.

module symbol_id_suffix_parser_core #(
  parameter int unsigned MAX_LEN         = 1024,
  parameter int unsigned MAX_CODE_DIGITS = 3
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic [7:0]                        char_code_i,
  input  wire logic                              last_char_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic                              ok_o,
  output      logic [sidp_pkg::NameLenW-1:0]     name_length_o,
  output      logic [sidp_pkg::IdW-1:0]          lib_code_o,
  output      logic [sidp_pkg::IdW-1:0]          mod_code_o
);

  logic              in_v_q;
  logic [7:0]        in_char_q;
  logic              in_last_q;
  logic              out_v_q;
  logic              step;
  sidp_pkg::result_t res, res_q;

  assign step       = in_v_q && (!in_last_q || !out_v_q || out_ready_i);
  assign in_ready_o = !in_v_q || step;

  sidp_parse #(
    .MAX_LEN         (MAX_LEN),
    .MAX_CODE_DIGITS (MAX_CODE_DIGITS)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .char_i   (in_char_q),
    .last_i   (in_last_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (step && in_last_q) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_char_q <= char_code_i;
      in_last_q <= last_char_i;
    end
    if (step && in_last_q) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_v_q;
  assign ok_o          = res_q.ok;
  assign name_length_o = res_q.name_length;
  assign lib_code_o    = res_q.lib_code;
  assign mod_code_o    = res_q.mod_code;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> name_length_o == '0 && lib_code_o == '0 && mod_code_o == '0)
    else $error("failed result carries non-zero fields");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(step && in_last_q))
    else $error("result appeared without a final character");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_v_q && in_last_q && out_v_q && !out_ready_i)
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

FILE: sim/tb_symbol_id_suffix_parser_core.sv
`timescale 1ns / 1ps

module tb_symbol_id_suffix_parser_core;

  localparam int unsigned MaxLen        = 1024;
  localparam int unsigned MaxCodeDigits = 3;
  localparam logic [7:0]  HashChar      = 8'h23;

  typedef enum logic [1:0] {
    PART_NAME,
    PART_LIBRARY,
    PART_MODULE,
    PART_FAILED
  } part_e;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic [7:0] char_code_i = 8'h00;
  logic last_char_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic ok_o;
  logic [sidp_pkg::NameLenW-1:0] name_length_o;
  logic [sidp_pkg::IdW-1:0]      lib_code_o;
  logic [sidp_pkg::IdW-1:0]      mod_code_o;

  sidp_pkg::result_t parse_results[$];
  int unsigned       error_count = 0;
  int unsigned       chars_sent  = 0;
  int unsigned       strings_sent = 0;
  bit                idling_on   = 1'b0;
  int unsigned       stall_left  = 0;

  part_e       part         = PART_NAME;
  int unsigned position     = 0;
  logic [9:0]  name_len     = '0;
  logic [17:0] lib_acc      = '0;
  int unsigned lib_digits   = 0;
  logic [17:0] mod_acc      = '0;
  int unsigned mod_digits   = 0;

  symbol_id_suffix_parser_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .last_char_i  (last_char_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ok_o         (ok_o),
    .name_length_o(name_length_o),
    .lib_code_o   (lib_code_o),
    .mod_code_o   (mod_code_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int alphabet_index(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "-") return 63;
    return -1;
  endfunction

  function automatic logic [7:0] alphabet_char(input int unsigned idx);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    if (idx == 62) return "+";
    return "-";
  endfunction

  function automatic logic [7:0] random_name_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == HashChar) c = 8'h00;
    return c;
  endfunction

  function automatic logic [7:0] random_invalid_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (alphabet_index(c) >= 0);
    return c;
  endfunction

  task automatic clear_parser();
    part       = PART_NAME;
    position   = 0;
    name_len   = '0;
    lib_acc    = '0;
    lib_digits = 0;
    mod_acc    = '0;
    mod_digits = 0;
  endtask

  task automatic parse_char(input logic [7:0] c, input logic last);
    int digit;
    sidp_pkg::result_t res;
    digit = alphabet_index(c);
    if (position <= MaxLen) position++;
    if (position > MaxLen) part = PART_FAILED;
    case (part)
      PART_NAME: begin
        if (c == HashChar) part = PART_LIBRARY;
        else name_len = name_len + 10'd1;
      end
      PART_LIBRARY: begin
        if (c == HashChar) part = PART_MODULE;
        else if (digit < 0 || lib_digits >= MaxCodeDigits) part = PART_FAILED;
        else begin
          lib_acc = {lib_acc[11:0], 6'(digit)};
          lib_digits++;
        end
      end
      PART_MODULE: begin
        if (digit < 0 || mod_digits >= MaxCodeDigits) part = PART_FAILED;
        else begin
          mod_acc = {mod_acc[11:0], 6'(digit)};
          mod_digits++;
        end
      end
      default: ;
    endcase
    if (last) begin
      res = '0;
      if (part == PART_MODULE) begin
        res.ok          = 1'b1;
        res.name_length = name_len;
        res.lib_code    = lib_acc[15:0];
        res.mod_code    = mod_acc[15:0];
      end
      parse_results.push_back(res);
      clear_parser();
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic last);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    last_char_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    parse_char(c, last);
    chars_sent++;
  endtask

  task automatic send_string(input logic [7:0] chars[$]);
    for (int i = 0; i < chars.size(); i++) send_char(chars[i], i == chars.size() - 1);
    strings_sent++;
  endtask

  task automatic send_text(input string s);
    logic [7:0] chars[$];
    for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
    send_string(chars);
  endtask

  task automatic send_padded(input int unsigned name_bytes, input string tail);
    logic [7:0] chars[$];
    for (int i = 0; i < name_bytes; i++) chars.push_back(random_name_char());
    for (int i = 0; i < tail.len(); i++) chars.push_back(tail[i]);
    send_string(chars);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (parse_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic compare_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      error_count++;
    end
  endtask

  task automatic check_result();
    sidp_pkg::result_t want;
    if (parse_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual ok=%0b len=%0h lib=%0h mod=%0h",
               $time, ok_o, name_length_o, lib_code_o, mod_code_o);
      error_count++;
    end else begin
      want = parse_results.pop_front();
      compare_field("ok", 16'(want.ok), 16'(ok_o));
      compare_field("name_length", 16'(want.name_length), 16'(name_length_o));
      compare_field("lib_code", want.lib_code, lib_code_o);
      compare_field("mod_code", want.mod_code, mod_code_o);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result();
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 11);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic test_well_formed();
    send_text("##");
    send_text("abc#---#---");
    send_text("x#A#A");
    send_text("sym#+9z#Q0");
    send_text("n#AB#");
    send_text("n##-");
  endtask

  task automatic test_name_bytes();
    logic [7:0] chars[$];
    chars = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h23, 8'h42, 8'h23, 8'h43};
    send_string(chars);
  endtask

  task automatic test_bad_code_bytes();
    logic [7:0] chars[$];
    chars = '{8'h61, 8'h23, 8'h00, 8'h23, 8'h41};
    send_string(chars);
    chars = '{8'h61, 8'h23, 8'h41, 8'h23, 8'hFF};
    send_string(chars);
    send_text("a#B#C#");
    send_text("a#B C#D");
  endtask

  task automatic test_missing_hash();
    send_text("abc");
    send_text("abc#AB");
    send_text("#");
  endtask

  task automatic test_long_code();
    send_text("a#ABCD#A");
    send_text("a#A#ABCD");
  endtask

  task automatic test_failed_state();
    send_text("q#AB!C#D##x#");
  endtask

  task automatic test_long_string();
    send_padded(MaxLen - 2, "##");
    send_padded(MaxLen - 1, "#A#B");
    send_text("ab#C#D");
  endtask

  task automatic send_random_string();
    logic [7:0]  chars[$];
    int unsigned kind;
    int unsigned lib_count;
    int unsigned mod_count;
    int unsigned hash_pos;
    int unsigned pos;
    kind      = $urandom_range(0, 15);
    lib_count = (kind == 1) ? MaxCodeDigits + 1 : $urandom_range(0, MaxCodeDigits);
    mod_count = (kind == 3) ? MaxCodeDigits + 1 : $urandom_range(0, MaxCodeDigits);
    if (kind == 0) begin
      repeat ($urandom_range(1, 10)) chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 10)) chars.push_back(random_name_char());
      hash_pos = chars.size();
      chars.push_back(HashChar);
      repeat (lib_count) chars.push_back(alphabet_char($urandom_range(0, 63)));
      if (kind != 2) chars.push_back(HashChar);
      repeat (mod_count) chars.push_back(alphabet_char($urandom_range(0, 63)));
      if (kind == 4) begin
        pos = $urandom_range(hash_pos + 1, chars.size());
        if (pos == chars.size()) chars.push_back(random_invalid_char());
        else chars[pos] = random_invalid_char();
      end
      if (kind == 5) begin
        chars.push_back(HashChar);
        chars.push_back(alphabet_char($urandom_range(0, 63)));
      end
    end
    send_string(chars);
  endtask

  task automatic test_random_mixed();
    int unsigned start_chars;
    start_chars = chars_sent;
    while (chars_sent - start_chars < 250) begin
      idling_on = ($urandom_range(0, 3) != 0);
      send_random_string();
    end
  endtask

  task automatic test_random_steady();
    int unsigned start_chars;
    idling_on   = 1'b0;
    start_chars = chars_sent;
    while (chars_sent - start_chars < 100) send_random_string();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idling_on = 1'b1;
    test_well_formed();
    test_name_bytes();
    test_bad_code_bytes();
    test_missing_hash();
    test_long_code();
    test_failed_state();
    test_long_string();
    wait_for_results();
    test_random_mixed();
    wait_for_results();
    test_random_steady();
    wait_for_results();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
